// ----- design/mtef_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtef_pkg
// Shared types and constants for the multichannel temperature EMA filter.
// ----------------------------------------------------------------------------
package mtef_pkg;

    localparam int TEMP_W    = 17;
    localparam int READING_W = 16;
    localparam int COUNT_W   = 5;
    localparam int CHAN_IN_W = 4;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic CFG_SENSORS_ENABLED = 1'b0;
    localparam logic CFG_DETECTED_COUNT  = 1'b1;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd10240;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd38400;
    localparam logic signed [15:0]       ALPHA_NUM = 16'sd13107;
    localparam int                       ALPHA_SHIFT = 16;

    typedef struct packed {
        logic do_init;
        logic do_clear;
        logic do_update;
    } ctrl_t;

endpackage
`default_nettype wire

// ----- design/mtef_ema.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtef_ema
// Clamps a raw reading and blends it into the old channel value
// with alpha = 13107/65536, floor rounding.
// ----------------------------------------------------------------------------
module mtef_ema
(
    input  wire logic signed [mtef_pkg::READING_W-1:0] reading,
    input  wire logic signed [mtef_pkg::TEMP_W-1:0]    old_value,
    output logic signed [mtef_pkg::TEMP_W-1:0]         new_value
);

    logic signed [mtef_pkg::TEMP_W-1:0]   reading_ext;
    logic signed [mtef_pkg::TEMP_W-1:0]   clamped;
    logic signed [mtef_pkg::TEMP_W:0]     diff;
    logic signed [mtef_pkg::TEMP_W+16:0]  product;
    logic signed [mtef_pkg::TEMP_W+16:0]  step;

    always_comb
    begin
        reading_ext = mtef_pkg::TEMP_W'(reading);
        if (reading_ext < mtef_pkg::TEMP_MIN)
        begin
            clamped = mtef_pkg::TEMP_MIN;
        end
        else if (reading_ext > mtef_pkg::TEMP_MAX)
        begin
            clamped = mtef_pkg::TEMP_MAX;
        end
        else
        begin
            clamped = reading_ext;
        end
        diff      = (mtef_pkg::TEMP_W+1)'(clamped) - (mtef_pkg::TEMP_W+1)'(old_value);
        product   = (mtef_pkg::TEMP_W+17)'(diff) * (mtef_pkg::TEMP_W+17)'(mtef_pkg::ALPHA_NUM);
        step      = product >>> mtef_pkg::ALPHA_SHIFT;
        new_value = old_value + step[mtef_pkg::TEMP_W-1:0];
    end

endmodule
`default_nettype wire

// ----- design/mtef_chan_state.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtef_chan_state
// Per-channel filtered values and health flags, plus the initialized flag.
// ----------------------------------------------------------------------------
module mtef_chan_state
#(
    parameter int CHANNELS = 4,
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mtef_pkg::ctrl_t                      ctrl,
    input  wire logic [CH_W-1:0]                      ch_idx,
    input  wire logic signed [mtef_pkg::TEMP_W-1:0]   new_value,
    input  wire logic [mtef_pkg::COUNT_W-1:0]         detected_count,
    output logic signed [mtef_pkg::TEMP_W-1:0]        old_value,
    output logic                                      old_healthy,
    output logic                                      init_done
);

    logic signed [mtef_pkg::TEMP_W-1:0] value_reg [CHANNELS];
    logic [CHANNELS-1:0]                healthy_reg;
    logic                               init_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                value_reg[i] <= '0;
            end
            healthy_reg   <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (ctrl.do_init)
                begin
                    value_reg[i]   <= '0;
                    healthy_reg[i] <= mtef_pkg::COUNT_W'(i) < detected_count;
                end
                else if (ctrl.do_clear)
                begin
                    value_reg[i]   <= '0;
                    healthy_reg[i] <= 1'b0;
                end
                else if (ctrl.do_update && (CH_W'(i) == ch_idx))
                begin
                    value_reg[i] <= new_value;
                end
            end
            if (ctrl.do_init)
            begin
                init_done_reg <= detected_count != '0;
            end
        end
    end

    assign old_value   = value_reg[ch_idx];
    assign old_healthy = healthy_reg[ch_idx];
    assign init_done   = init_done_reg;

endmodule
`default_nettype wire

// ----- design/multichannel_temperature_ema_filter_core.sv -----
// Path: an accepted item passes through the input register and then the result register.
// Throughput: one word per cycle unless the output stalls; the channel state is updated
// in the same cycle the item moves from the input register to the result register.
// Reset: asynchronous, active low; clears all channel values, health flags and the
// initialized flag, sets sensors_enabled to 1 and detected_count to 0.
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_temperature_ema_filter_core
// Per-channel exponential moving average of temperature readings with
// init, sample and query operations.
// ----------------------------------------------------------------------------
module multichannel_temperature_ema_filter_core
#(
    parameter int CHANNELS = 4
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [mtef_pkg::COUNT_W-1:0]         cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           operation,
    input  wire logic [mtef_pkg::CHAN_IN_W-1:0]       channel,
    input  wire logic signed [mtef_pkg::READING_W-1:0] reading,
    input  wire logic                                 reading_valid,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [mtef_pkg::TEMP_W-1:0]        channel_temperature,
    output logic                                      channel_ok,
    output logic                                      initialized
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                                  sensors_enabled_reg;
    logic [mtef_pkg::COUNT_W-1:0]          detected_count_reg;

    logic                                  in_valid_reg;
    logic [1:0]                            op_reg;
    logic [mtef_pkg::CHAN_IN_W-1:0]        channel_reg;
    logic signed [mtef_pkg::READING_W-1:0] reading_reg;
    logic                                  reading_valid_reg;

    logic                                  out_valid_reg;
    logic signed [mtef_pkg::TEMP_W-1:0]    temp_reg;
    logic                                  ok_reg;
    logic                                  init_reg;

    logic                                  accept;
    logic                                  advance;
    logic                                  in_range;
    logic                                  is_init;
    logic                                  is_sample;
    logic                                  update_cond;
    logic [CH_W-1:0]                       ch_idx;
    logic signed [mtef_pkg::TEMP_W-1:0]    old_value;
    logic signed [mtef_pkg::TEMP_W-1:0]    new_value;
    logic                                  old_healthy;
    logic                                  init_done;
    mtef_pkg::ctrl_t                       ctrl;

    logic signed [mtef_pkg::TEMP_W-1:0]    temp_next;
    logic                                  ok_next;
    logic                                  init_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensors_enabled_reg <= 1'b1;
            detected_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mtef_pkg::CFG_SENSORS_ENABLED: sensors_enabled_reg <= cfg_wdata[0];
                mtef_pkg::CFG_DETECTED_COUNT:  detected_count_reg  <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg            <= operation;
            channel_reg       <= channel;
            reading_reg       <= reading;
            reading_valid_reg <= reading_valid;
        end
    end

    assign in_range  = {1'b0, channel_reg} < mtef_pkg::COUNT_W'(CHANNELS);
    assign ch_idx    = channel_reg[CH_W-1:0];
    assign is_init   = op_reg == mtef_pkg::OP_INIT;
    assign is_sample = op_reg == mtef_pkg::OP_SAMPLE;
    assign update_cond = is_sample && sensors_enabled_reg && in_range
                         && old_healthy && reading_valid_reg;

    assign ctrl.do_init   = advance && is_init;
    assign ctrl.do_clear  = advance && is_sample && !sensors_enabled_reg;
    assign ctrl.do_update = advance && update_cond;

    mtef_ema u_ema
    (
        .reading   (reading_reg),
        .old_value (old_value),
        .new_value (new_value)
    );

    mtef_chan_state #(.CHANNELS(CHANNELS)) u_state
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .ch_idx         (ch_idx),
        .new_value      (new_value),
        .detected_count (detected_count_reg),
        .old_value      (old_value),
        .old_healthy    (old_healthy),
        .init_done      (init_done)
    );

    always_comb
    begin
        init_next = is_init ? (detected_count_reg != '0) : init_done;
        if (!in_range)
        begin
            temp_next = '0;
            ok_next   = 1'b0;
        end
        else if (is_init)
        begin
            temp_next = '0;
            ok_next   = {1'b0, channel_reg} < detected_count_reg;
        end
        else if (is_sample && !sensors_enabled_reg)
        begin
            temp_next = '0;
            ok_next   = 1'b0;
        end
        else if (update_cond)
        begin
            temp_next = new_value;
            ok_next   = old_healthy;
        end
        else
        begin
            temp_next = old_value;
            ok_next   = old_healthy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            temp_reg <= temp_next;
            ok_reg   <= ok_next;
            init_reg <= init_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign channel_temperature = temp_reg;
    assign channel_ok          = ok_reg;
    assign initialized         = init_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_init_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_init) |=> (initialized == ($past(detected_count_reg) != '0)))
        else $error("initialized does not follow detected count after init");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_range) |=> (channel_temperature == '0 && !channel_ok))
        else $error("out-of-range channel returned nonzero result");

    a_disabled_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_sample && !sensors_enabled_reg)
        |=> (channel_temperature == '0 && !channel_ok))
        else $error("disabled sample did not clear channel");
`endif

endmodule
`default_nettype wire
